/* sv/hrst_pkg.sv */
// ----------------------------------------------------------------------------
// hrst_pkg
// shared types and constants of the hash ring successor table
// ----------------------------------------------------------------------------
package hrst_pkg;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned POINT_W    = 32;
  localparam int unsigned NODE_W     = 4;
  localparam int unsigned RANK_W     = 4;
  localparam int unsigned STATUS_W   = 2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_KEPT     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [POINT_W-1:0] point;
    logic [NODE_W-1:0]  owner;
    logic [RANK_W-1:0]  rank;
  } entry_t;

  typedef struct packed {
    logic                load;
    logic                rd_mid;
    logic                step;
    logic                rd_sel;
    logic                rd_prev;
    logic                shift_init;
    logic                rd_shift;
    logic                wr_shift;
    logic                wr_new;
    logic                wr_coll;
    logic                set_res;
    logic                res_found;
    logic                res_own_mem;
    logic [STATUS_W-1:0] res_status;
    logic                ld_out;
  } cmd_t;

  typedef struct packed {
    logic srch_busy;
    logic is_lookup;
    logic empty;
    logic coll;
    logic keep;
    logic full;
    logic shift_done;
  } sts_t;

endpackage

/* sv/hrst_if.sv */
// ----------------------------------------------------------------------------
// hrst_req_if / hrst_rsp_if
// valid/ready channels carrying request and response transactions
// ----------------------------------------------------------------------------
interface hrst_req_if;
  import hrst_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [POINT_W-1:0] hash_value;
  logic [NODE_W-1:0]  node_index;
  logic [RANK_W-1:0]  name_rank;

  modport source (output valid, func, hash_value, node_index, name_rank, input ready);
  modport sink   (input valid, func, hash_value, node_index, name_rank, output ready);
endinterface

interface hrst_rsp_if;
  import hrst_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [NODE_W-1:0]   owner_node;
  logic [STATUS_W-1:0] status;

  modport source (output valid, found, owner_node, status, input ready);
  modport sink   (input valid, found, owner_node, status, output ready);
endinterface

/* sv/hrst_datapath.sv */
// ----------------------------------------------------------------------------
// hrst_datapath
// ring memory, binary search bounds, shift pointer and result registers
// ----------------------------------------------------------------------------
module hrst_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hrst_pkg::cmd_t                cmd_i,
  output hrst_pkg::sts_t                sts_o,
  input  logic                          func_i,
  input  logic [hrst_pkg::POINT_W-1:0]  hash_value_i,
  input  logic [hrst_pkg::NODE_W-1:0]   node_index_i,
  input  logic [hrst_pkg::RANK_W-1:0]   name_rank_i,
  output logic                          found_o,
  output logic [hrst_pkg::NODE_W-1:0]   owner_node_o,
  output logic [hrst_pkg::STATUS_W-1:0] status_o
);
  import hrst_pkg::*;

  entry_t mem_q [RING_DEPTH];
  entry_t rdata_q;

  logic               func_q;
  logic [POINT_W-1:0] key_q;
  logic [NODE_W-1:0]  node_q;
  logic [RANK_W-1:0]  rank_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] mid_q;
  logic [CNT_W-1:0] mid;

  logic                res_found_q;
  logic [NODE_W-1:0]   res_owner_q;
  logic [STATUS_W-1:0] res_status_q;

  logic             rd_en;
  logic [IDX_W-1:0] raddr;
  logic             wr_en;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  entry_t           new_entry;

  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign new_entry = '{point: key_q, owner: node_q, rank: rank_q};

  // memory port selection
  always_comb begin
    rd_en = cmd_i.rd_mid | cmd_i.rd_sel | cmd_i.rd_prev | cmd_i.rd_shift;
    raddr = '0;
    priority if (cmd_i.rd_mid) begin
      raddr = mid[IDX_W-1:0];
    end else if (cmd_i.rd_sel) begin
      raddr = (lo_q >= count_q) ? '0 : lo_q[IDX_W-1:0];
    end else if (cmd_i.rd_prev) begin
      raddr = lo_q[IDX_W-1:0] - 1'b1;
    end else if (cmd_i.rd_shift) begin
      raddr = ptr_q[IDX_W-1:0] - 1'b1;
    end
  end

  always_comb begin
    wr_en = cmd_i.wr_shift | cmd_i.wr_new | cmd_i.wr_coll;
    waddr = '0;
    wdata = new_entry;
    priority if (cmd_i.wr_shift) begin
      waddr = ptr_q[IDX_W-1:0];
      wdata = rdata_q;
    end else if (cmd_i.wr_new) begin
      waddr = lo_q[IDX_W-1:0];
    end else if (cmd_i.wr_coll) begin
      waddr = lo_q[IDX_W-1:0] - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // search bounds, shift pointer and fill count
  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    ptr_d   = ptr_q;
    count_d = count_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hi_d = count_q;
    end
    if (cmd_i.step) begin
      if (rdata_q.point > key_q) begin
        hi_d = mid_q;
      end else begin
        lo_d = mid_q + 1'b1;
      end
    end
    if (cmd_i.shift_init) begin
      ptr_d = count_q;
    end
    if (cmd_i.wr_shift) begin
      ptr_d = ptr_q - 1'b1;
    end
    if (cmd_i.wr_new) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      ptr_q   <= '0;
    end else begin
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= hash_value_i;
      node_q <= node_index_i;
      rank_q <= name_rank_i;
    end
    if (cmd_i.rd_mid) begin
      mid_q <= mid;
    end
    if (cmd_i.set_res) begin
      res_found_q  <= cmd_i.res_found;
      res_owner_q  <= cmd_i.res_own_mem ? rdata_q.owner : '0;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.ld_out) begin
      found_o      <= res_found_q;
      owner_node_o <= res_owner_q;
      status_o     <= res_status_q;
    end
  end

  always_comb begin
    sts_o.srch_busy  = lo_q < hi_q;
    sts_o.is_lookup  = func_q == FUNC_LOOKUP;
    sts_o.empty      = count_q == '0;
    sts_o.coll       = (lo_q != '0) && (rdata_q.point == key_q);
    sts_o.keep       = rdata_q.rank < rank_q;
    sts_o.full       = count_q == CNT_W'(RING_DEPTH);
    sts_o.shift_done = ptr_q == lo_q;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(RING_DEPTH))
    else $error("ring fill count beyond depth");

  a_no_add_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |-> (count_q < CNT_W'(RING_DEPTH)))
    else $error("new point written into a full ring");

  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("search bounds crossed");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_shift |-> (ptr_q > lo_q) && (ptr_q <= count_q))
    else $error("shift outside the occupied range");
`endif

endmodule

/* sv/hrst_ctrl.sv */
// ----------------------------------------------------------------------------
// hrst_ctrl
// sequencer for search, collision check, entry shift and result hand-off
// ----------------------------------------------------------------------------
module hrst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  hrst_pkg::sts_t sts_i,
  output hrst_pkg::cmd_t cmd_o
);
  import hrst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_LKW  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_SHR  = 3'd5;
  localparam logic [2:0] S_SHW  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SRCH;
        end
      end
      S_SRCH: begin
        priority if (sts_i.srch_busy) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = S_CMP;
        end else if (sts_i.is_lookup && sts_i.empty) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_DONE;
          state_d          = S_OUT;
        end else if (sts_i.is_lookup) begin
          cmd_o.rd_sel = 1'b1;
          state_d      = S_LKW;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = S_CHK;
        end
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = S_SRCH;
      end
      S_LKW: begin
        cmd_o.set_res     = 1'b1;
        cmd_o.res_found   = 1'b1;
        cmd_o.res_own_mem = 1'b1;
        cmd_o.res_status  = ST_DONE;
        state_d           = S_OUT;
      end
      S_CHK: begin
        cmd_o.set_res = 1'b1;
        priority if (sts_i.coll && sts_i.keep) begin
          cmd_o.res_status = ST_KEPT;
          state_d          = S_OUT;
        end else if (sts_i.coll) begin
          cmd_o.wr_coll    = 1'b1;
          cmd_o.res_status = ST_REPLACED;
          state_d          = S_OUT;
        end else if (sts_i.full) begin
          cmd_o.res_status = ST_FULL;
          state_d          = S_OUT;
        end else begin
          cmd_o.set_res    = 1'b0;
          cmd_o.shift_init = 1'b1;
          state_d          = S_SHR;
        end
      end
      S_SHR: begin
        if (sts_i.shift_done) begin
          cmd_o.wr_new     = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_DONE;
          state_d          = S_OUT;
        end else begin
          cmd_o.rd_shift = 1'b1;
          state_d        = S_SHW;
        end
      end
      S_SHW: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = S_SHR;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SRCH))
    else $error("accepted transaction did not start a search");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.wr_shift, cmd_o.wr_new, cmd_o.wr_coll}))
    else $error("more than one memory write in a cycle");
`endif

endmodule

/* sv/hash_ring_successor_table_unit.sv */
// ----------------------------------------------------------------------------
// hash_ring_successor_table_unit
// sorted ring of hash points with insert and successor lookup
// ----------------------------------------------------------------------------
// req_i carries one transaction per item: func selects insert or lookup,
// hash_value is the point or key, node_index and name_rank qualify inserts.
// rsp_o returns exactly one transaction per request: found and owner_node
// for a lookup, status for an insert.
// one request is worked on at a time. a search step is a memory read then a
// compare. an insert of a new point first moves each stored point above it up
// by one place, one entry per read/write pair of the ring memory.
// the finished result sits in an output register: a new request is taken
// while it waits, and when the receiver stalls the next result is held back
// until the register drains.
// reset empties the ring at once (fill count to zero); the memory contents
// are left as they are and no clearing pass is needed.
// ----------------------------------------------------------------------------
module hash_ring_successor_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  hrst_req_if.sink    req_i,
  hrst_rsp_if.source  rsp_o
);
  import hrst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hrst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hrst_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (req_i.func),
    .hash_value_i (req_i.hash_value),
    .node_index_i (req_i.node_index),
    .name_rank_i  (req_i.name_rank),
    .found_o      (rsp_o.found),
    .owner_node_o (rsp_o.owner_node),
    .status_o     (rsp_o.status)
  );

endmodule
